// File: hw/rtl/tvf_pkg.sv
// Shared types and constants for the voxel fusion block.
package tvf_pkg;

	localparam logic [1:0] CMD_COEF  = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_FUSE  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [4:0]  NUM_POSE      = 5'd12;
	localparam logic [4:0]  NUM_COEF      = 5'd21;
	localparam logic [15:0] DEPTH_INVALID = 16'hFFFF;
	localparam logic [15:0] WEIGHT_MAX    = 16'hFFFF;
	localparam logic [14:0] TRUNC_RESET   = 15'd410;

	// clipped distance handed from front to back
	localparam int SDF_W = 19;

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         voxel_x;
		logic [5:0]         voxel_y;
		logic [5:0]         voxel_z;
		logic [18:0]        pixel_index;
		logic [15:0]        depth_sample;
		logic [4:0]         coefficient_index;
		logic signed [31:0] coefficient_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] sdf_value;
		logic [15:0]        fusion_weight;
		logic               voxel_updated;
	} result_t;

	typedef struct packed {
		logic ingrid;
		logic upd;
	} vop_flags_t;

endpackage

// File: hw/rtl/tvf_if.sv
// Item and result channel interfaces.
interface tvf_item_if;
	tvf_pkg::item_t data;
	logic           valid;
	logic           ready;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tvf_result_if;
	tvf_pkg::result_t data;
	logic             valid;
	logic             ready;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/tvf_pixdiv.sv
// Pipelined restoring divider, one quotient bit per stage.
module tvf_pixdiv #(
	parameter int NW = 49,
	parameter int QW = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [NW-1:0] rem_q [QW];
	logic [NW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int B = QW - 1 - k;
		logic [NW-1:0]    r_in;
		logic [NW-1:0]    d_in;
		logic [QW-1:0]    q_in;
		logic [NW+QW-1:0] dsh;
		logic             take;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
		end

		assign dsh  = {{QW{1'b0}}, d_in} << B;
		assign take = {{QW{1'b0}}, r_in} >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? r_in - dsh[NW-1:0] : r_in;
				den_q[k] <= d_in;
				quo_q[k] <= q_in | (QW'(take) << B);
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

// File: hw/rtl/tvf_front.sv
// Front end: accept, coefficient and depth writes, projection and depth lookup.
module tvf_front #(
	parameter int GRID_SIZE    = 64,
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tvf_item_if.sink               item,
	input  logic                   accept_ok,
	input  logic [14:0]            trunc,
	output logic                   op_valid,
	input  logic                   op_ready,
	output tvf_pkg::vop_flags_t    op_flags,
	output logic [3*$clog2(GRID_SIZE)-1:0] op_vaddr,
	output logic signed [tvf_pkg::SDF_W-1:0] op_sdf
);

	localparam int AW   = $clog2(GRID_SIZE);
	localparam int VAW  = 3 * AW;
	localparam int NPIX = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int PAW  = $clog2(NPIX);
	localparam int FMAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
	localparam int QW   = $clog2(FMAX);
	localparam int HALF = GRID_SIZE / 2;
	localparam int QG   = 131072 / GRID_SIZE;
	localparam int RG   = 131072 % GRID_SIZE;
	localparam int RM   = ((1 << 28) + GRID_SIZE - 1) / GRID_SIZE;
	localparam int NUMW = 49;

	localparam logic signed [52:0] S_MAX = 53'sd2147483647;
	localparam logic signed [52:0] S_MIN = -53'sd2147483648;
	localparam logic signed [29:0] SDF_CAP = 30'sd131072;

	typedef struct packed {
		logic               vld;
		logic [1:0]         cmd;
		logic               ingrid;
		logic [VAW-1:0]     vaddr;
		logic [PAW-1:0]     paddr;
		logic               pwe;
		logic [15:0]        depth;
		logic [4:0]         cidx;
		logic signed [31:0] cval;
		logic signed [27:0] cz4;
	} ctl_t;

	logic en;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10;
	ctl_t ctl_dq [QW];
	logic ok_dq [QW];

	logic signed [31:0] pc_q [12];
	logic signed [31:0] kc_q [9];

	logic [18:0]        t_s2 [3];
	logic [17:0]        b_s2 [3];
	logic               neg_s2;
	logic signed [18:0] c_s3 [3];
	logic signed [50:0] pr_s4 [9];
	logic signed [31:0] p3_s4 [3];
	logic signed [31:0] cam_s5 [3];
	logic signed [63:0] kp_s6 [9];
	logic signed [49:0] pix_s7 [3];
	logic [NUMW-1:0]    numx_s8, numy_s8, den_s8;
	logic               ok_s8;
	logic               inf_s9, inf_s10;
	logic [PAW-1:0]     daddr_s9;
	logic [15:0]        dq_s10;
	logic [15:0]        dmem [NPIX];

	// accept
	logic [9:0]  xe, ye, ze;
	logic [24:0] pe;
	ctl_t        ctl_in;

	always_comb begin
		xe = {4'b0, item.data.voxel_x};
		ye = {4'b0, item.data.voxel_y};
		ze = {4'b0, item.data.voxel_z};
		pe = {6'b0, item.data.pixel_index};
		ctl_in.vld    = item.valid && item.ready;
		ctl_in.cmd    = item.data.command;
		ctl_in.ingrid = (xe < 10'(GRID_SIZE)) && (ye < 10'(GRID_SIZE)) && (ze < 10'(GRID_SIZE));
		ctl_in.vaddr  = {ze[AW-1:0], ye[AW-1:0], xe[AW-1:0]};
		ctl_in.paddr  = pe[PAW-1:0];
		ctl_in.pwe    = pe < 25'(NPIX);
		ctl_in.depth  = item.data.depth_sample;
		ctl_in.cidx   = item.data.coefficient_index;
		ctl_in.cval   = item.data.coefficient_value;
		ctl_in.cz4    = '0;
	end

	assign item.ready = en && accept_ok;

	// s1: voxel coordinate magnitudes
	logic signed [10:0] nx;
	logic [9:0]         a_s1 [3];
	logic               neg_s1;

	always_comb begin
		nx      = 11'(HALF) - {1'b0, 10'(ctl_s1.vaddr[AW-1:0])};
		neg_s1  = nx[10];
		a_s1[0] = neg_s1 ? 10'(-nx) : nx[9:0];
		a_s1[1] = 10'(ctl_s1.vaddr[3*AW-1:2*AW]);
		a_s1[2] = 10'(ctl_s1.vaddr[2*AW-1:AW]);
	end

	// s2: divide by grid size through reciprocal
	logic [46:0]        fr_s2 [3];
	logic [17:0]        cu_s2 [3];
	logic signed [18:0] c_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fr_s2[i] = (47'(t_s2[i]) * 47'(RM)) >> 28;
			cu_s2[i] = b_s2[i] + fr_s2[i][17:0];
			c_s2[i]  = {1'b0, cu_s2[i]};
		end
		if (neg_s2)
			c_s2[0] = -{1'b0, cu_s2[0]};
	end

	// s3: pose products
	logic signed [50:0] pr_s3 [9];

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				pr_s3[3*i+j] = 51'(pc_q[4*i+j]) * 51'(c_s3[j]);
	end

	// s4: camera point, saturated
	logic signed [52:0] acc_s4 [3];
	logic signed [52:0] sum_s4 [3];
	logic signed [31:0] cam_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_s4[i] = 53'(pr_s4[3*i]) + 53'(pr_s4[3*i+1]) + 53'(pr_s4[3*i+2]);
			sum_s4[i] = (acc_s4[i] >>> 16) + 53'(p3_s4[i]);
			if (sum_s4[i] > S_MAX)
				cam_s4[i] = 32'sh7FFFFFFF;
			else if (sum_s4[i] < S_MIN)
				cam_s4[i] = -32'sh80000000;
			else
				cam_s4[i] = 32'(sum_s4[i]);
		end
	end

	// s5: intrinsic products
	logic signed [63:0] kp_s5 [9];
	ctl_t               ctl_cz;

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				kp_s5[3*i+j] = 64'(kc_q[3*i+j]) * 64'(cam_s5[j]);
		ctl_cz     = ctl_s5;
		ctl_cz.cz4 = 28'(cam_s5[2] >>> 4);
	end

	// s6: projected point
	logic signed [49:0] pix_s6 [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			pix_s6[i] = 50'(kp_s6[3*i] >>> 16) + 50'(kp_s6[3*i+1] >>> 16)
				+ 50'(kp_s6[3*i+2] >>> 16);
	end

	// s7: divider set-up and range pre-checks
	logic             pzpos, okx, oky;
	logic [NUMW-1:0]  numx, numy;

	always_comb begin
		pzpos = !pix_s7[2][49] && (pix_s7[2] != '0);
		if (pix_s7[0][49]) begin
			okx  = (-pix_s7[0]) < pix_s7[2];
			numx = '0;
		end else begin
			okx  = {{QW{1'b0}}, pix_s7[0][NUMW-1:0]} < {pix_s7[2][NUMW-1:0], {QW{1'b0}}};
			numx = pix_s7[0][NUMW-1:0];
		end
		if (pix_s7[1][49]) begin
			oky  = (-pix_s7[1]) < pix_s7[2];
			numy = '0;
		end else begin
			oky  = {{QW{1'b0}}, pix_s7[1][NUMW-1:0]} < {pix_s7[2][NUMW-1:0], {QW{1'b0}}};
			numy = pix_s7[1][NUMW-1:0];
		end
	end

	logic [QW-1:0] col, row;

	tvf_pixdiv #(.NW(NUMW), .QW(QW)) u_divx (
		.clk (clk), .en (en), .num (numx_s8), .den (den_s8), .quo (col)
	);

	tvf_pixdiv #(.NW(NUMW), .QW(QW)) u_divy (
		.clk (clk), .en (en), .num (numy_s8), .den (den_s8), .quo (row)
	);

	// after divider: frame check and depth address
	logic        inf_d;
	logic [24:0] daddr_d;

	always_comb begin
		inf_d   = ok_dq[QW-1] && ({1'b0, col} < (QW+1)'(FRAME_WIDTH))
			&& ({1'b0, row} < (QW+1)'(FRAME_HEIGHT));
		daddr_d = 25'(row) * 25'(FRAME_WIDTH) + 25'(col);
	end

	// s10: distance and update decision
	logic signed [29:0] sdf;
	logic signed [29:0] tneg;
	logic               upd;

	always_comb begin
		sdf  = $signed({14'b0, dq_s10}) - 30'(ctl_s10.cz4);
		tneg = -$signed({15'b0, trunc});
		upd  = (ctl_s10.cmd == tvf_pkg::CMD_FUSE) && inf_s10
			&& (dq_s10 != tvf_pkg::DEPTH_INVALID) && (sdf > tneg);
		op_valid = ctl_s10.vld
			&& ((ctl_s10.cmd == tvf_pkg::CMD_FUSE) || (ctl_s10.cmd == tvf_pkg::CMD_READ));
		op_flags.ingrid = ctl_s10.ingrid;
		op_flags.upd    = upd && ctl_s10.ingrid;
		op_vaddr        = ctl_s10.vaddr;
		op_sdf          = (sdf > SDF_CAP) ? tvf_pkg::SDF_W'(SDF_CAP)
			: tvf_pkg::SDF_W'(sdf);
	end

	assign en = !(op_valid && !op_ready);

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			for (int k = 0; k < QW; k++)
				ctl_dq[k] <= '0;
			for (int k = 0; k < 12; k++)
				pc_q[k] <= '0;
			for (int k = 0; k < 9; k++)
				kc_q[k] <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_cz;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_dq[0] <= ctl_s8;
			for (int k = 1; k < QW; k++)
				ctl_dq[k] <= ctl_dq[k-1];
			ctl_s9  <= ctl_dq[QW-1];
			ctl_s10 <= ctl_s9;
			// pose used at s3, intrinsics at s5: writes land there too
			if (ctl_s3.vld && (ctl_s3.cmd == tvf_pkg::CMD_COEF)
				&& (ctl_s3.cidx < tvf_pkg::NUM_POSE))
				pc_q[ctl_s3.cidx[3:0]] <= ctl_s3.cval;
			if (ctl_s5.vld && (ctl_s5.cmd == tvf_pkg::CMD_COEF)
				&& (ctl_s5.cidx >= tvf_pkg::NUM_POSE) && (ctl_s5.cidx < tvf_pkg::NUM_COEF))
				kc_q[4'(ctl_s5.cidx - tvf_pkg::NUM_POSE)] <= ctl_s5.cval;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t_s2[i]   <= 19'(a_s1[i]) * 19'(RG);
				b_s2[i]   <= 18'(a_s1[i]) * 18'(QG);
				c_s3[i]   <= c_s2[i];
				p3_s4[i]  <= pc_q[4*i+3];
				cam_s5[i] <= cam_s4[i];
				pix_s7[i] <= pix_s6[i];
			end
			neg_s2 <= neg_s1;
			for (int k = 0; k < 9; k++) begin
				pr_s4[k] <= pr_s3[k];
				kp_s6[k] <= kp_s5[k];
			end
			numx_s8  <= numx;
			numy_s8  <= numy;
			den_s8   <= pix_s7[2][NUMW-1:0];
			ok_s8    <= pzpos && okx && oky;
			ok_dq[0] <= ok_s8;
			for (int k = 1; k < QW; k++)
				ok_dq[k] <= ok_dq[k-1];
			inf_s9   <= inf_d;
			daddr_s9 <= daddr_d[PAW-1:0];
			inf_s10  <= inf_s9;
		end
	end

	// depth frame
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s9.vld && (ctl_s9.cmd == tvf_pkg::CMD_PIXEL) && ctl_s9.pwe)
				dmem[ctl_s9.paddr] <= ctl_s9.depth;
			dq_s10 <= dmem[daddr_s9];
		end
	end

endmodule

// File: hw/rtl/tvf_queue.sv
// Short FIFO between front and back.
module tvf_queue #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         not_full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         not_empty
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign not_full  = cnt_q != (PW+1)'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign dout      = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (not_full || pop))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && not_full) |=> not_empty)
		else $error("queue count lost a transfer");

endmodule

// File: hw/rtl/tvf_back.sv
// Back end: voxel store clear, read-modify-write and result register.
module tvf_back #(
	parameter int VAW = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [14:0]           trunc,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  tvf_pkg::vop_flags_t   q_flags,
	input  logic [VAW-1:0]        q_vaddr,
	input  logic signed [tvf_pkg::SDF_W-1:0] q_sdf,
	output logic                  clr_done,
	tvf_result_if.source          result
);

	logic [31:0]          vmem [2**VAW];
	logic                 clr_q;
	logic [VAW-1:0]       clr_cnt_q;
	logic                 v_b1;
	tvf_pkg::vop_flags_t  flags_b1;
	logic [VAW-1:0]       addr_b1;
	logic signed [tvf_pkg::SDF_W-1:0] sdf_b1;
	logic [31:0]          rd_b1;
	logic                 fwd_b1;
	logic [31:0]          fwdw_b1;
	logic                 res_valid_q;
	tvf_pkg::result_t     res_q;

	logic               go, wr;
	logic [31:0]        oldw, neww;
	logic signed [15:0] old_sdf;
	logic [15:0]        old_w, new_w;
	logic signed [19:0] sum;
	logic signed [19:0] half;
	logic signed [19:0] tpos;
	logic signed [15:0] new_sdf;

	assign clr_done = !clr_q;
	assign go       = v_b1 && (!res_valid_q || result.ready);
	assign q_pop    = q_valid && !clr_q && (!v_b1 || go);
	assign wr       = go && flags_b1.ingrid && flags_b1.upd;

	always_comb begin
		oldw    = fwd_b1 ? fwdw_b1 : rd_b1;
		old_sdf = oldw[31:16];
		old_w   = oldw[15:0];
		sum     = 20'(old_sdf) + 20'(sdf_b1);
		half    = sum >>> 1;
		tpos    = $signed({5'b0, trunc});
		if (half > tpos)
			new_sdf = 16'(tpos);
		else if (half < -tpos)
			new_sdf = 16'(-tpos);
		else
			new_sdf = 16'(half);
		new_w = (old_w == tvf_pkg::WEIGHT_MAX) ? old_w : old_w + 16'd1;
		neww  = {new_sdf, new_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			v_b1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q)
					clr_q <= 1'b0;
			end
			if (q_pop)
				v_b1 <= 1'b1;
			else if (go)
				v_b1 <= 1'b0;
			if (go)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			vmem[clr_cnt_q] <= '0;
		else if (wr)
			vmem[addr_b1] <= neww;
		if (q_pop) begin
			rd_b1    <= vmem[q_vaddr];
			flags_b1 <= q_flags;
			addr_b1  <= q_vaddr;
			sdf_b1   <= q_sdf;
			fwd_b1   <= wr && (addr_b1 == q_vaddr);
			fwdw_b1  <= neww;
		end
		if (go) begin
			if (!flags_b1.ingrid)
				res_q <= '0;
			else if (flags_b1.upd)
				res_q <= {new_sdf, new_w, 1'b1};
			else
				res_q <= {old_sdf, old_w, 1'b0};
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !q_pop)
		else $error("transfer taken during clear");
	a_upd_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.voxel_updated) |-> (res_q.fusion_weight != '0))
		else $error("update with zero weight");
	a_upd_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.voxel_updated) |->
		((20'(res_q.sdf_value) <= tpos) && (20'(res_q.sdf_value) >= -tpos)))
		else $error("updated distance outside truncation");

endmodule

// File: hw/rtl/tsdf_voxel_fusion_core.sv
// Top level of the truncated signed distance voxel fusion block.
//
// channel  dir  handshake      carries
// item     in   valid/ready    tvf_pkg::item_t command and operands
// result   out  valid/ready    tvf_pkg::result_t voxel value, weight, update flag
// cfg      in   cfg_we         truncation distance, 15 bits
//
// One item per cycle sustained while the queue has room; a result passes
// through the projection pipeline and the per-bit pixel divider. After
// reset the voxel store is swept to zero with item.ready low. A stalled
// result holds the back end; the front keeps taking items until the
// 4-entry queue fills.
module tsdf_voxel_fusion_core #(
	parameter int GRID_SIZE    = 64,
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [14:0]   cfg_data,
	tvf_item_if.sink      item,
	tvf_result_if.source  result
);

	localparam int VAW = 3 * $clog2(GRID_SIZE);
	localparam int FW  = $bits(tvf_pkg::vop_flags_t);
	localparam int OPW = FW + VAW + tvf_pkg::SDF_W;

	logic [14:0]           trunc_q;
	logic                  clr_done;
	logic                  op_valid, q_not_full, q_not_empty, q_pop;
	tvf_pkg::vop_flags_t   op_flags, q_flags;
	logic [VAW-1:0]        op_vaddr, q_vaddr;
	logic signed [tvf_pkg::SDF_W-1:0] op_sdf, q_sdf;
	logic [OPW-1:0]        q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			trunc_q <= tvf_pkg::TRUNC_RESET;
		else if (cfg_we)
			trunc_q <= cfg_data;
	end

	tvf_front #(
		.GRID_SIZE    (GRID_SIZE),
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.accept_ok (clr_done),
		.trunc     (trunc_q),
		.op_valid  (op_valid),
		.op_ready  (q_not_full),
		.op_flags  (op_flags),
		.op_vaddr  (op_vaddr),
		.op_sdf    (op_sdf)
	);

	tvf_queue #(.W(OPW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_valid && q_not_full),
		.din       ({op_flags, op_vaddr, op_sdf}),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.dout      (q_dout),
		.not_empty (q_not_empty)
	);

	assign q_flags = q_dout[OPW-1 -: FW];
	assign q_vaddr = q_dout[tvf_pkg::SDF_W +: VAW];
	assign q_sdf   = q_dout[tvf_pkg::SDF_W-1:0];

	tvf_back #(.VAW(VAW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.trunc    (trunc_q),
		.q_valid  (q_not_empty),
		.q_pop    (q_pop),
		.q_flags  (q_flags),
		.q_vaddr  (q_vaddr),
		.q_sdf    (q_sdf),
		.clr_done (clr_done),
		.result   (result)
	);

endmodule

// File: bench/tvf_checker.sv
// Checker: predicts voxel fusion results from observed transfers and compares them.
module tvf_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [14:0]  cfg_data,
	tvf_item_if          item,
	tvf_result_if        result,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GS = 64;
	localparam int FW = 640;
	localparam int FH = 480;

	logic signed [63:0] coef [0:20];
	logic [15:0] frame [int];
	logic signed [15:0] dist_mem [int];
	logic [15:0] wgt_mem [int];
	logic [14:0] trunc_q;
	tvf_pkg::result_t expected_q [$];

	function automatic logic signed [63:0] fdiv(logic signed [63:0] a, logic signed [63:0] d);
		logic signed [63:0] q;
		q = a / d;
		if ((a % d) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	function automatic tvf_pkg::result_t fuse_voxel(tvf_pkg::item_t it);
		tvf_pkg::result_t r;
		logic signed [63:0] c [3];
		logic signed [63:0] cam [3];
		logic signed [63:0] pix [3];
		logic signed [63:0] acc, px, py, sdf, v, t;
		int vox;
		logic [15:0] d, w;
		vox = (int'(it.voxel_z) * GS + int'(it.voxel_y)) * GS + int'(it.voxel_x);
		r.sdf_value = dist_mem.exists(vox) ? dist_mem[vox] : 16'sd0;
		r.fusion_weight = wgt_mem.exists(vox) ? wgt_mem[vox] : 16'd0;
		r.voxel_updated = 1'b0;
		if (it.command == tvf_pkg::CMD_READ) return r;
		c[0] = ((64'sd32 - $signed({58'd0, it.voxel_x})) * 64'sd131072) / 64'sd64;
		c[1] = ($signed({58'd0, it.voxel_z}) * 64'sd131072) / 64'sd64;
		c[2] = ($signed({58'd0, it.voxel_y}) * 64'sd131072) / 64'sd64;
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++) acc += coef[4*i+j] * c[j];
			cam[i] = fdiv(acc, 64'sd65536) + coef[4*i+3];
			if (cam[i] > 64'sd2147483647) cam[i] = 64'sd2147483647;
			if (cam[i] < -64'sd2147483648) cam[i] = -64'sd2147483648;
		end
		for (int i = 0; i < 3; i++) begin
			pix[i] = '0;
			for (int j = 0; j < 3; j++)
				pix[i] += fdiv(coef[12+3*i+j] * cam[j], 64'sd65536);
		end
		if (pix[2] <= 0) return r;
		px = pix[0] / pix[2];
		py = pix[1] / pix[2];
		if (px < 0 || px >= FW || py < 0 || py >= FH) return r;
		d = frame.exists(int'(py * FW + px)) ? frame[int'(py * FW + px)] : 16'd0;
		if (d == tvf_pkg::DEPTH_INVALID) return r;
		t = $signed({49'd0, trunc_q});
		sdf = $signed({48'd0, d}) - fdiv(cam[2], 64'sd16);
		if (!(sdf > -t)) return r;
		v = fdiv(64'(r.sdf_value) + sdf, 64'sd2);
		if (v > t) v = t;
		if (v < -t) v = -t;
		w = r.fusion_weight;
		if (w != tvf_pkg::WEIGHT_MAX) w++;
		dist_mem[vox] = v[15:0];
		wgt_mem[vox] = w;
		r.sdf_value = v[15:0];
		r.fusion_weight = w;
		r.voxel_updated = 1'b1;
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 21; i++) coef[i] = '0;
			trunc_q = tvf_pkg::TRUNC_RESET;
			fail_count = 0;
			expected_q.delete();
			dist_mem.delete();
			wgt_mem.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					tvf_pkg::result_t e;
					e = expected_q.pop_front();
					if (e.sdf_value !== result.data.sdf_value) begin
						$error("sdf_value exp %0d got %0d", e.sdf_value, result.data.sdf_value);
						fail_count++;
					end
					if (e.fusion_weight !== result.data.fusion_weight) begin
						$error("fusion_weight exp %0d got %0d", e.fusion_weight,
							result.data.fusion_weight);
						fail_count++;
					end
					if (e.voxel_updated !== result.data.voxel_updated) begin
						$error("voxel_updated exp %0d got %0d", e.voxel_updated,
							result.data.voxel_updated);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready) begin
				tvf_pkg::item_t it;
				it = item.data;
				case (it.command)
					tvf_pkg::CMD_COEF: begin
						if (it.coefficient_index < tvf_pkg::NUM_COEF)
							coef[it.coefficient_index] = 64'(it.coefficient_value);
					end
					tvf_pkg::CMD_PIXEL: begin
						if (it.pixel_index < FW * FH) frame[int'(it.pixel_index)] = it.depth_sample;
					end
					default: begin
						expected_q.push_back(fuse_voxel(it));
					end
				endcase
			end
			if (cfg_we) trunc_q = cfg_data;
		end
	end
endmodule

// File: bench/testbench.sv
// Top of the voxel fusion bench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_data = '0;
	int fail_count, pending;
	longint cycles = 0;
	bit written_px [int];
	logic signed [63:0] tb_coef [21];

	tvf_item_if item ();
	tvf_result_if result ();

	tsdf_voxel_fusion_core DUT (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .item(item.sink), .result(result.source));

	tvf_checker u_checker (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.item(item), .result(result), .fail_count(fail_count), .pending(pending));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		item.valid = 1'b0;
		item.data = '0;
		result.ready = 1'b0;
		for (int i = 0; i < 21; i++) tb_coef[i] = '0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 64'd2000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
		end
	end

	task automatic send(tvf_pkg::item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.data <= it;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
	endtask

	function automatic tvf_pkg::item_t blank(logic [1:0] cmd);
		tvf_pkg::item_t it;
		it = '0;
		it.command = cmd;
		return it;
	endfunction

	function automatic logic signed [63:0] fdiv(logic signed [63:0] a, logic signed [63:0] d);
		logic signed [63:0] q;
		q = a / d;
		if ((a % d) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	// depth pixel a fuse of this voxel would read, or -1 if none
	function automatic int target_px(int x, int y, int z);
		logic signed [63:0] c [3];
		logic signed [63:0] cam [3];
		logic signed [63:0] pix [3];
		logic signed [63:0] acc, px, py;
		c[0] = (64'(32 - x) * 64'sd131072) / 64'sd64;
		c[1] = (64'(z) * 64'sd131072) / 64'sd64;
		c[2] = (64'(y) * 64'sd131072) / 64'sd64;
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++) acc += tb_coef[4*i+j] * c[j];
			cam[i] = fdiv(acc, 64'sd65536) + tb_coef[4*i+3];
			if (cam[i] > 64'sd2147483647) cam[i] = 64'sd2147483647;
			if (cam[i] < -64'sd2147483648) cam[i] = -64'sd2147483648;
		end
		for (int i = 0; i < 3; i++) begin
			pix[i] = '0;
			for (int j = 0; j < 3; j++)
				pix[i] += fdiv(tb_coef[12+3*i+j] * cam[j], 64'sd65536);
		end
		if (pix[2] <= 0) return -1;
		px = pix[0] / pix[2];
		py = pix[1] / pix[2];
		if (px < 0 || px >= 640 || py < 0 || py >= 480) return -1;
		return int'(py * 640 + px);
	endfunction

	task automatic set_coef(int idx, int val);
		tvf_pkg::item_t it;
		it = blank(tvf_pkg::CMD_COEF);
		it.coefficient_index = 5'(idx);
		it.coefficient_value = val;
		send(it);
		if (idx >= 0 && idx < 21) tb_coef[5'(idx)] = 64'(val);
	endtask

	task automatic set_pixel(int idx, int val);
		tvf_pkg::item_t it;
		it = blank(tvf_pkg::CMD_PIXEL);
		it.pixel_index = 19'(idx);
		it.depth_sample = 16'(val);
		send(it);
		if (idx >= 0 && idx < 307200) written_px[idx] = 1'b1;
	endtask

	task automatic voxel_op(logic [1:0] cmd, int x, int y, int z);
		tvf_pkg::item_t it;
		int tp;
		if (cmd == tvf_pkg::CMD_FUSE) begin
			tp = target_px(x, y, z);
			if (tp >= 0 && !written_px.exists(tp))
				set_pixel(tp, ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 16383));
		end
		it = blank(cmd);
		it.voxel_x = 6'(x);
		it.voxel_y = 6'(y);
		it.voxel_z = 6'(z);
		send(it);
	endtask

	// Pose mapping voxels in front of camera, intrinsics fx=fy=fscale, centre 320,240.
	task automatic load_camera(int tz, int fscale);
		int p [21];
		p = '{65536, 0, 0, 0, 0, 0, 65536, 0, 0, 65536, 0, tz,
			fscale, 0, 320 * 65536, 0, fscale, 240 * 65536, 0, 0, 65536};
		for (int i = 0; i < 21; i++) set_coef(i, p[i]);
	endtask

	task automatic fill_frame(int n, logic full);
		for (int i = 0; i < n; i++) begin
			int idx;
			idx = full ? i * 641 % 307200 : $urandom_range(0, 307199);
			set_pixel(idx, ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 65534));
		end
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_trunc(int v);
		cfg_we <= 1'b1;
		cfg_data <= 15'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random coefficient and pixel writes, fuse/read mostly on voxels whose projection lands in the frame
	task automatic random_phase(int n);
		for (int k = 0; k < n; k++) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 3) set_coef($urandom_range(0, 31), $urandom());
			else if (r < 10) set_pixel($urandom_range(0, 524287), $urandom_range(0, 65535));
			else if (r < 30) voxel_op(tvf_pkg::CMD_READ, $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 63));
			else if (r < 34) voxel_op(tvf_pkg::CMD_FUSE, $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 63));
			else voxel_op($urandom_range(0, 1) ? tvf_pkg::CMD_FUSE : tvf_pkg::CMD_READ,
				$urandom_range(28, 36), $urandom_range(28, 36), $urandom_range(1, 63));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fill_frame(32, 1'b1);
		// directed
		voxel_op(tvf_pkg::CMD_READ, 0, 0, 0);
		voxel_op(tvf_pkg::CMD_FUSE, 63, 63, 63);
		voxel_op(tvf_pkg::CMD_FUSE, 32, 32, 32);
		load_camera(65536, 300 * 65536);
		voxel_op(tvf_pkg::CMD_FUSE, 32, 32, 10);
		voxel_op(tvf_pkg::CMD_FUSE, 32, 32, 10);
		voxel_op(tvf_pkg::CMD_FUSE, 0, 0, 63);
		voxel_op(tvf_pkg::CMD_FUSE, 63, 63, 0);
		voxel_op(tvf_pkg::CMD_READ, 32, 32, 10);
		set_coef(31, -1);
		set_coef(20, -2147483648);
		voxel_op(tvf_pkg::CMD_FUSE, 32, 32, 10);
		set_coef(20, 2147483647);
		set_coef(11, -2147483648);
		voxel_op(tvf_pkg::CMD_FUSE, 33, 33, 33);
		set_pixel(524287, 16'hFFFF);
		set_pixel(307199, 0);
		set_pixel(0, 65535);
		drain();
		write_trunc(1);
		load_camera(65536, 300 * 65536);
		random_phase(130);
		drain();
		write_trunc(32767);
		random_phase(130);
		drain();
		write_trunc(0);
		load_camera(-20000, 200 * 65536);
		random_phase(100);
		drain();
		write_trunc(410);
		load_camera(32768, 500 * 65536);
		random_phase(130);
		drain();
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
